FILE: rtl/iso8583_pkg.sv
//------------------------------------------------------------------------------
// ISO 8583 parser package
// Shared types, phase codes and a helper function of the message parser.
//------------------------------------------------------------------------------
package iso8583_pkg;

	localparam int FIELD_SLOTS_DEF   = 192;
	localparam int MAX_FIELD_LEN_DEF = 999;

	typedef enum logic [2:0] {
		PH_TYPE   = 3'd0,
		PH_BITMAP = 3'd1,
		PH_LENGTH = 3'd2,
		PH_DATA   = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_EMIT,
		ST_SCAN,
		ST_FETCH,
		ST_FINISH
	} ctrl_state_t;

	localparam logic [1:0] KIND_FIXED = 2'd0;
	localparam logic [1:0] KIND_LL    = 2'd1;
	localparam logic [1:0] ENC_RAW    = 2'd0;
	localparam logic [1:0] ENC_LEFT   = 2'd2;

	localparam logic [1:0] STATUS_DATA      = 2'd0;
	localparam logic [1:0] STATUS_COMPLETE  = 2'd1;
	localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
	localparam logic [1:0] STATUS_SHORT     = 2'd3;

	localparam logic [0:0] CMD_BYTE  = 1'b0;
	localparam logic [0:0] CMD_TABLE = 1'b1;

	localparam logic [0:0] REG_TYPE_ASCII = 1'b0;
	localparam logic [0:0] REG_LEN_ASCII  = 1'b1;

	localparam logic [7:0] CHAR_D  = 8'h44;
	localparam logic [7:0] CHAR_EQ = 8'h3D;
	localparam logic [7:0] TRACK2  = 8'd35;
	localparam logic [7:0] TRACK3  = 8'd36;
	localparam int         MIN_MESSAGE_BYTES = 10;

	typedef struct packed {
		logic [0:0] command;
		logic [7:0] data_byte;
		logic       end_of_message;
		logic [7:0] entry_index;
		logic [1:0] entry_length_kind;
		logic [1:0] entry_encoding;
		logic [9:0] entry_length;
	} in_item_t;

	typedef struct packed {
		logic [7:0] field_number;
		logic [7:0] data_char;
		logic [9:0] field_length;
		logic       last_in_field;
		logic [1:0] status;
		logic       last_result;
	} out_item_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load_byte;   // capture accepted item
		logic lookup;      // register the table entry of the current field
		logic process;     // run the byte through the parse phase
		logic scan_step;   // examine one candidate field position
		logic emit_next;   // one result taken, advance to the next
		logic finish;      // finish the item; on end of message, clear message state
	} ctrl_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic scan_busy;   // next-field search still running
		logic more_results;// further results pending for this item
		logic is_table;    // captured item is a table write
		logic eom;         // captured byte ends the message
	} dp_status_t;

	function automatic logic [7:0] nib_char(input logic [3:0] n);
		return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
	endfunction

endpackage

FILE: rtl/iso8583_ctrl.sv
//------------------------------------------------------------------------------
// ISO 8583 parser controller
// Sequences capture, table lookup, byte processing, field search and output.
//------------------------------------------------------------------------------
module iso8583_ctrl import iso8583_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t stat,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (stat.is_table) state_d = ST_IDLE;
				else state_d = ST_FETCH;
			end
			ST_FETCH: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!stat.scan_busy) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.more_results) state_d = ST_EMIT;
				else state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (out_ready && !stat.more_results) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_byte = in_valid;
			end
			ST_LOOKUP: cmd.lookup = 1'b1;
			ST_FETCH:  cmd.process = 1'b1;
			ST_SCAN:   cmd.scan_step = stat.scan_busy;
			ST_FINISH: cmd.finish = 1'b1;
			ST_EMIT: begin
				out_valid     = 1'b1;
				cmd.emit_next = out_ready;
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/iso8583_dp.sv
//------------------------------------------------------------------------------
// ISO 8583 parser datapath
// Format table, message state, bitmap store and a small result queue.
//------------------------------------------------------------------------------
module iso8583_dp import iso8583_pkg::*; #(
	parameter int FIELD_SLOTS   = FIELD_SLOTS_DEF,
	parameter int MAX_FIELD_LEN = MAX_FIELD_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_item,
	input  logic       type_in_ascii,
	input  logic       length_in_ascii,
	input  ctrl_cmd_t  cmd,
	output dp_status_t stat,
	output out_item_t  out_item
);

	localparam logic [9:0] MAXL = 10'(MAX_FIELD_LEN);

	logic [13:0]  table_mem [FIELD_SLOTS];
	logic [13:0]  entry_q;
	in_item_t     item_q;
	logic [191:0] map_q;
	phase_t       phase_q;
	logic [7:0]   field_q;
	logic [9:0]   remain_q;
	logic [9:0]   acc_q;
	logic [11:0]  pos_q;
	logic [1:0]   bmcnt_q;
	logic         scan_q;
	logic [7:0]   scan_pos_q;
	// result queue: up to three entries
	out_item_t    res_q [3];
	logic [1:0]   res_cnt_q;
	logic [1:0]   res_rd_q;

	// Table write and registered read. The scan reads at scan_pos_q.
	logic [7:0] rd_addr;
	always_comb begin
		rd_addr = scan_q ? scan_pos_q : field_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup && item_q.command == CMD_TABLE &&
		    {1'b0, item_q.entry_index} < 9'(FIELD_SLOTS)) begin
			table_mem[item_q.entry_index] <= {item_q.entry_length_kind,
				item_q.entry_encoding, item_q.entry_length};
		end
		entry_q <= table_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) item_q <= in_item;
	end

	function automatic logic [9:0] sat(input logic [13:0] v);
		return (v > {4'd0, MAXL}) ? MAXL : v[9:0];
	endfunction

	// Combinational byte processing (one phase step).
	logic [191:0] map_n;
	phase_t       phase_n;
	logic [9:0]   remain_n, acc_n;
	logic [1:0]   bmcnt_n;
	logic         scan_n;
	logic [7:0]   scan_start;
	out_item_t    r0, r1;
	logic [1:0]   nres;

	always_comb begin
		logic [7:0]  b;
		logic [1:0]  k;
		logic [2:0]  idx;
		logic [1:0]  kind, enc;
		logic [13:0] t;
		logic [3:0]  d;
		logic        lastb, odd, first, h_en, l_en;
		logic [7:0]  fn, ch_h, ch_l;
		b = item_q.data_byte;
		k = 2'd0; idx = 3'd0; kind = entry_q[13:12]; enc = entry_q[11:10];
		t = '0; d = '0; lastb = 1'b0; odd = 1'b0; first = 1'b0;
		h_en = 1'b0; l_en = 1'b0; fn = field_q + 8'd1;
		ch_h = nib_char(b[7:4]); ch_l = nib_char(b[3:0]);
		map_n = map_q; phase_n = phase_q; remain_n = remain_q; acc_n = acc_q;
		bmcnt_n = bmcnt_q; scan_n = 1'b0; scan_start = 8'd1;
		r0 = '0; r1 = '0; nres = 2'd0;
		unique case (phase_q)
			PH_TYPE: begin
				r0.field_length = 10'd4; r1.field_length = 10'd4;
				if (type_in_ascii) begin
					r0.data_char = b; r0.last_in_field = pos_q >= 12'd3;
					nres = 2'd1;
					if (pos_q >= 12'd3) begin
						phase_n = PH_BITMAP; bmcnt_n = 2'd0; remain_n = 10'd8;
					end
				end else begin
					r0.data_char = ch_h; r1.data_char = ch_l;
					r1.last_in_field = pos_q >= 12'd1; nres = 2'd2;
					if (pos_q >= 12'd1) begin
						phase_n = PH_BITMAP; bmcnt_n = 2'd0; remain_n = 10'd8;
					end
				end
			end
			PH_BITMAP: begin
				k = (bmcnt_q > 2'd2) ? 2'd2 : bmcnt_q;
				idx = 3'(4'd8 - ((remain_q[2:0] != 3'd0) ? {1'b0, remain_q[2:0]}
					: 4'd8));
				for (int j = 0; j < 8; j++) begin
					if (b[7-j]) map_n[{k, idx, 3'(j)}] = 1'b1;
				end
				remain_n = (remain_q != 10'd0) ? remain_q - 10'd1 : 10'd0;
				if (remain_n == 10'd0) begin
					bmcnt_n = k + 2'd1;
					if (k < 2'd2 && map_n[{k, 6'd0}]) begin
						remain_n = 10'd8;
					end else begin
						scan_n = 1'b1; scan_start = 8'd1;
					end
				end
			end
			PH_LENGTH: begin
				if (length_in_ascii) begin
					d = (b >= 8'h30 && b <= 8'h39) ? b[3:0] : 4'd0;
					t = {4'd0, acc_q} * 14'd10 + {10'd0, d};
				end else if (kind != KIND_LL && remain_q >= 10'd2) begin
					t = {10'd0, b[3:0]} * 14'd100;
				end else begin
					t = {4'd0, acc_q} + {10'd0, b[7:4]} * 14'd10 + {10'd0, b[3:0]};
				end
				acc_n = sat(t);
				remain_n = (remain_q != 10'd0) ? remain_q - 10'd1 : 10'd0;
				if (remain_n == 10'd0) begin
					if (acc_n == 10'd0) begin
						scan_n = 1'b1; scan_start = field_q + 8'd1;
					end else begin
						phase_n = PH_DATA;
						remain_n = (enc == ENC_RAW) ? acc_n
							: 10'(({1'b0, acc_n} + 11'd1) >> 1);
					end
				end
			end
			PH_DATA: begin
				lastb = remain_q <= 10'd1;
				r0.field_number = fn; r1.field_number = fn;
				r0.field_length = acc_q; r1.field_length = acc_q;
				if (enc == ENC_RAW) begin
					r0.data_char = b; r0.last_in_field = lastb; nres = 2'd1;
				end else begin
					odd = acc_q[0];
					first = remain_q == 10'(({1'b0, acc_q} + 11'd1) >> 1);
					if ((fn == TRACK2 || fn == TRACK3) && ch_h == CHAR_D) ch_h = CHAR_EQ;
					if ((fn == TRACK2 || fn == TRACK3) && ch_l == CHAR_D) ch_l = CHAR_EQ;
					h_en = !(enc == ENC_LEFT && first && odd);
					l_en = !(enc != ENC_LEFT && lastb && odd);
					if (h_en && l_en) begin
						r0.data_char = ch_h; r1.data_char = ch_l;
						r1.last_in_field = lastb; nres = 2'd2;
					end else if (h_en) begin
						r0.data_char = ch_h; r0.last_in_field = lastb; nres = 2'd1;
					end else if (l_en) begin
						r0.data_char = ch_l; r0.last_in_field = lastb; nres = 2'd1;
					end
				end
				remain_n = (remain_q != 10'd0) ? remain_q - 10'd1 : 10'd0;
				if (remain_n == 10'd0) begin
					scan_n = 1'b1; scan_start = field_q + 8'd1;
				end
			end
			default: ;
		endcase
	end

	// One scan step: examine position scan_pos_q with entry_q for it.
	logic       sc_hit, sc_end;
	logic [9:0] sc_len;
	always_comb begin
		sc_end = {1'b0, scan_pos_q} >= 9'(FIELD_SLOTS);
		sc_len = sat({4'd0, entry_q[9:0]});
		sc_hit = !sc_end && scan_pos_q[5:0] != 6'd0 && map_q[scan_pos_q];
	end

	// status result assembled at finish
	logic [1:0] eom_st;
	always_comb begin
		if (pos_q < 12'(MIN_MESSAGE_BYTES)) eom_st = STATUS_SHORT;
		else if (phase_q == PH_DONE) eom_st = STATUS_COMPLETE;
		else eom_st = STATUS_TRUNCATED;
	end

	// The scan reads the table through the registered read port: scan_pos_q addresses memory,
	// entry_q then holds its entry. A wait flag keeps them aligned.
	logic wait_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= '0; phase_q <= PH_TYPE; field_q <= '0; remain_q <= '0;
			acc_q <= '0; pos_q <= '0; bmcnt_q <= '0; scan_q <= 1'b0;
			scan_pos_q <= '0; res_cnt_q <= '0; res_rd_q <= '0; wait_q <= 1'b0;
		end else begin
			if (cmd.process && item_q.command == CMD_BYTE) begin
				map_q <= map_n; phase_q <= phase_n; remain_q <= remain_n;
				acc_q <= acc_n; bmcnt_q <= bmcnt_n;
				if (pos_q != 12'hFFF) pos_q <= pos_q + 12'd1;
				scan_q <= scan_n; scan_pos_q <= scan_start; wait_q <= 1'b1;
				res_q[0] <= r0; res_q[1] <= r1; res_cnt_q <= nres;
				res_rd_q <= 2'd0;
			end
			if (cmd.scan_step) begin
				if (wait_q) begin
					wait_q <= 1'b0;
				end else if (sc_end) begin
					scan_q <= 1'b0; phase_q <= PH_DONE;
				end else if (sc_hit) begin
					field_q <= scan_pos_q;
					if (entry_q[13:12] == KIND_FIXED) begin
						if (sc_len == 10'd0) begin
							scan_pos_q <= scan_pos_q + 8'd1; wait_q <= 1'b1;
						end else begin
							scan_q <= 1'b0; acc_q <= sc_len; phase_q <= PH_DATA;
							remain_q <= (entry_q[11:10] == ENC_RAW) ? sc_len
								: 10'(({1'b0, sc_len} + 11'd1) >> 1);
						end
					end else begin
						scan_q <= 1'b0; phase_q <= PH_LENGTH; acc_q <= '0;
						if (entry_q[13:12] == KIND_LL)
							remain_q <= length_in_ascii ? 10'd2 : 10'd1;
						else
							remain_q <= length_in_ascii ? 10'd3 : 10'd2;
					end
				end else begin
					scan_pos_q <= scan_pos_q + 8'd1; wait_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				if (item_q.end_of_message) begin
					res_q[res_cnt_q] <= '{field_number: '0, data_char: '0,
						field_length: '0, last_in_field: 1'b0, status: eom_st,
						last_result: 1'b0};
					res_cnt_q <= res_cnt_q + 2'd1;
					map_q <= '0; phase_q <= PH_TYPE; field_q <= '0;
					remain_q <= '0; acc_q <= '0; pos_q <= '0; bmcnt_q <= '0;
				end
			end
			if (cmd.emit_next) res_rd_q <= res_rd_q + 2'd1;
		end
	end

	always_comb begin
		stat.scan_busy    = scan_q;
		stat.is_table     = item_q.command == CMD_TABLE;
		stat.eom          = item_q.end_of_message;
		stat.more_results = cmd.emit_next ? (res_rd_q + 2'd1 < res_cnt_q)
			: (res_rd_q < res_cnt_q) || (cmd.finish && item_q.end_of_message);
		out_item             = res_q[res_rd_q];
		out_item.last_result = (res_rd_q + 2'd1 == res_cnt_q);
	end

endmodule

FILE: rtl/iso8583_message_parser.sv
//------------------------------------------------------------------------------
// ISO 8583 message parser
// Unpacks a byte stream into the characters of each present message field.
//------------------------------------------------------------------------------
// Each accepted transaction is either a message byte or a format table write.
// A table write is captured and then stored. A message byte is captured, looked up
// and processed, then finished, and its results (up to three) are delivered; when it
// ends a field or a bitmap, the next-field search runs before finishing; it examines
// bitmap positions by walking the format table memory one position at a time through its
// registered read port. Results are presented on the output channel one
// at a time; last_result marks the final result caused by a transaction.
// A message byte with end_of_message set appends one status result and
// returns all message state to its reset value; the format table is kept.
// Table entries that were never written must not be referenced by a message.
//------------------------------------------------------------------------------
module iso8583_message_parser import iso8583_pkg::*; #(
	parameter int FIELD_SLOTS   = FIELD_SLOTS_DEF,
	parameter int MAX_FIELD_LEN = MAX_FIELD_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [0:0] cfg_wdata
);

	logic       type_ascii_q, len_ascii_q;
	ctrl_cmd_t  cmd;
	dp_status_t stat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_ascii_q <= 1'b0;
			len_ascii_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TYPE_ASCII: type_ascii_q <= cfg_wdata[0];
				REG_LEN_ASCII:  len_ascii_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	iso8583_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	iso8583_dp #(
		.FIELD_SLOTS   (FIELD_SLOTS),
		.MAX_FIELD_LEN (MAX_FIELD_LEN)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_item         (in_data),
		.type_in_ascii   (type_ascii_q),
		.length_in_ascii (len_ascii_q),
		.cmd             (cmd),
		.stat            (stat),
		.out_item        (out_data)
	);

endmodule
